### hw/rtl/hsl_pkg.sv
`default_nettype none
package hsl_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int SIZE_W = 11;
  localparam int X_W = $clog2(MAX_SIZE);
  localparam int ADDR_W = X_W + 1;
  localparam int STORE_DEPTH = 2 * MAX_SIZE;
  localparam int PADDR_W = 4;

  localparam logic [PADDR_W-3:0] REG_FRAME_SIZE = 2'd0;
  localparam logic [PADDR_W-3:0] REG_SLOPE_GAIN = 2'd1;
  localparam logic [PADDR_W-3:0] REG_MIN_BRIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] FRAME_SIZE_RST = 11'd256;
  localparam logic [23:0] SLOPE_GAIN_RST = 24'd4096;
  localparam logic [15:0] MIN_BRIGHT_RST = 16'd13107;

  // 2 * 65535 * 4096
  localparam logic [39:0] K2 = 40'd536862720;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_MUL_A,
    DP_MUL_B,
    DP_NORM,
    DP_SQ_A,
    DP_SQ_B,
    DP_SQ_K,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_NMUL,
    DP_LIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ld_in;
    logic   ld_l;
    logic   ld_r;
    logic   ld_d;
    logic   ld_u_mem;
    logic   ld_u_in;
    logic   d_from_u;
    logic   last;
  } hsl_cmd_t;

  typedef struct packed {
    logic out_full;
  } hsl_stat_t;

endpackage
`default_nettype wire

### hw/rtl/hsl_if.sv
`default_nettype none
interface hsl_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] height;
  modport source (output valid, output opcode, output height, input ready);
  modport sink (input valid, input opcode, input height, output ready);
endinterface

interface hsl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] lighting;
  logic        frame_last;
  modport source (output valid, output lighting, output frame_last, input ready);
  modport sink (input valid, input lighting, input frame_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/hsl_ram.sv
`default_nettype none
module hsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/hsl_ctrl.sv
`default_nettype none
module hsl_ctrl
  import hsl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [SIZE_W-1:0] frame_size,
  input  wire logic              size_wr,
  input  wire hsl_stat_t         stat,
  output hsl_cmd_t               cmd,
  output logic                   ram_we,
  output logic      [ADDR_W-1:0] ram_waddr,
  output logic      [ADDR_W-1:0] ram_raddr
);

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_MUL_A, S_MUL_B, S_NORM, S_SQ_A, S_SQ_B, S_SQ_K,
    S_SQRT_I, S_SQRT, S_DIV_I, S_DIV, S_NMUL, S_LIT
  } state_t;

  state_t            state_r;
  logic [SIZE_W-1:0] col_r, row_r, fl_r;
  logic [ADDR_W-1:0] addr_l_r, addr_r_r, addr_d_r, addr_u_r, addr_w_r;
  logic              flush_r, last_r, one_row_r;
  logic [4:0]        step_r;

  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] x, r, p, xl, xr, x1;
  logic              accept;

  always_comb begin
    if (frame_size == '0) begin
      size = SIZE_W'(1);
    end else if (frame_size > SIZE_W'(MAX_SIZE)) begin
      size = SIZE_W'(MAX_SIZE);
    end else begin
      size = frame_size;
    end
  end

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    x = in_opcode ? fl_r : col_r;
    r = in_opcode ? size - SIZE_W'(1) : row_r;
    p = r - SIZE_W'(1);
    x1 = x + SIZE_W'(1);
    xl = (x == '0) ? '0 : x - SIZE_W'(1);
    xr = (x1 >= size) ? size - SIZE_W'(1) : x1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r <= '0;
      row_r <= '0;
      fl_r <= '0;
      step_r <= '0;
      flush_r <= 1'b0;
      last_r <= 1'b0;
      one_row_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (size_wr) begin
            col_r <= '0;
            row_r <= '0;
            fl_r <= '0;
          end else if (accept) begin
            flush_r <= in_opcode;
            one_row_r <= (size == SIZE_W'(1));
            if (!in_opcode) begin
              if (row_r < size) begin
                last_r <= 1'b0;
                addr_l_r <= {p[0], xl[X_W-1:0]};
                addr_r_r <= {p[0], xr[X_W-1:0]};
                addr_d_r <= (r >= SIZE_W'(2)) ? {r[0], x[X_W-1:0]} : {p[0], x[X_W-1:0]};
                addr_w_r <= {r[0], x[X_W-1:0]};
                if (x1 >= size) begin
                  col_r <= '0;
                  row_r <= r + SIZE_W'(1);
                end else begin
                  col_r <= x1;
                end
                state_r <= (r >= SIZE_W'(1)) ? S_RD0 : S_WR;
              end
            end else if (row_r >= size && fl_r < size) begin
              addr_l_r <= {r[0], xl[X_W-1:0]};
              addr_r_r <= {r[0], xr[X_W-1:0]};
              addr_u_r <= {r[0], x[X_W-1:0]};
              addr_d_r <= {p[0], x[X_W-1:0]};
              if (x1 >= size) begin
                last_r <= 1'b1;
                col_r <= '0;
                row_r <= '0;
                fl_r <= '0;
              end else begin
                last_r <= 1'b0;
                fl_r <= x1;
              end
              state_r <= S_RD0;
            end
          end
        end
        S_WR: state_r <= S_IDLE;
        S_RD0: state_r <= S_RD1;
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= S_RD3;
        S_RD3: state_r <= flush_r ? S_RD4 : S_MUL_A;
        S_RD4: state_r <= S_MUL_A;
        S_MUL_A: state_r <= S_MUL_B;
        S_MUL_B: state_r <= S_NORM;
        S_NORM: state_r <= S_SQ_A;
        S_SQ_A: state_r <= S_SQ_B;
        S_SQ_B: state_r <= S_SQ_K;
        S_SQ_K: state_r <= S_SQRT_I;
        S_SQRT_I: begin
          step_r <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'd31) begin
            state_r <= S_DIV_I;
          end
        end
        S_DIV_I: begin
          step_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'd30) begin
            state_r <= S_NMUL;
          end
        end
        S_NMUL: state_r <= S_LIT;
        S_LIT: begin
          if (!stat.out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.op = DP_NOP;
    cmd.last = last_r;
    cmd.ld_in = accept;
    ram_we = 1'b0;
    ram_waddr = addr_w_r;
    ram_raddr = addr_l_r;
    case (state_r)
      S_WR: ram_we = 1'b1;
      S_RD0: ram_raddr = addr_l_r;
      S_RD1: begin
        ram_raddr = addr_r_r;
        cmd.ld_l = 1'b1;
      end
      S_RD2: begin
        ram_raddr = flush_r ? addr_u_r : addr_d_r;
        cmd.ld_r = 1'b1;
      end
      S_RD3: begin
        ram_raddr = addr_d_r;
        if (flush_r) begin
          cmd.ld_u_mem = 1'b1;
        end else begin
          cmd.ld_d = 1'b1;
          cmd.ld_u_in = 1'b1;
          ram_we = 1'b1;
        end
      end
      S_RD4: begin
        if (one_row_r) begin
          cmd.d_from_u = 1'b1;
        end else begin
          cmd.ld_d = 1'b1;
        end
      end
      S_MUL_A: cmd.op = DP_MUL_A;
      S_MUL_B: cmd.op = DP_MUL_B;
      S_NORM: cmd.op = DP_NORM;
      S_SQ_A: cmd.op = DP_SQ_A;
      S_SQ_B: cmd.op = DP_SQ_B;
      S_SQ_K: cmd.op = DP_SQ_K;
      S_SQRT_I: cmd.op = DP_SQRT_INIT;
      S_SQRT: cmd.op = DP_SQRT_STEP;
      S_DIV_I: cmd.op = DP_DIV_INIT;
      S_DIV: cmd.op = DP_DIV_STEP;
      S_NMUL: cmd.op = DP_NMUL;
      S_LIT: cmd.op = DP_LIT;
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/hsl_dp.sv
`default_nettype none
module hsl_dp
  import hsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hsl_cmd_t    cmd,
  output hsl_stat_t        stat,
  input  wire logic [15:0] in_height,
  input  wire logic [15:0] ram_rdata,
  output logic      [15:0] height,
  input  wire logic [23:0] slope_gain,
  input  wire logic [15:0] min_bright,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_lighting,
  output logic             out_last
);

  logic [15:0] h_r, hl_r, hr_r, hd_r, hu_r;
  logic [39:0] a_r, b_r;
  logic [30:0] as_r, bs_r, ks_r;
  logic [63:0] acc_r, v_r, res_r, bit_r;
  logic [33:0] rem_r;
  logic [30:0] dsh_r, q_r;
  logic [45:0] n_r;
  logic        out_valid_r, last_r;
  logic [15:0] lit_r;

  logic [31:0] mx_a, mx_b;
  logic [63:0] prod;
  logic [15:0] dx, dz, mv, span;
  logic [39:0] mx;
  logic [3:0]  sh;
  logic [39:0] a_sh, b_sh, k_sh;
  logic [63:0] trial;
  logic [33:0] t;
  logic [30:0] ny;
  logic [46:0] s;
  logic [16:0] lit;
  logic [15:0] lit_c;

  assign dx = (hr_r >= hl_r) ? hr_r - hl_r : hl_r - hr_r;
  assign dz = (hu_r >= hd_r) ? hu_r - hd_r : hd_r - hu_r;
  assign mv = (min_bright > ONE_Q15) ? ONE_Q15 : min_bright;
  assign span = ONE_Q15 - mv;
  assign ny = (q_r > 31'(1 << 30)) ? 31'(1 << 30) : q_r;

  always_comb begin
    case (cmd.op)
      DP_MUL_A: begin
        mx_a = {16'd0, dx};
        mx_b = {8'd0, slope_gain};
      end
      DP_MUL_B: begin
        mx_a = {16'd0, dz};
        mx_b = {8'd0, slope_gain};
      end
      DP_SQ_A: begin
        mx_a = {1'b0, as_r};
        mx_b = {1'b0, as_r};
      end
      DP_SQ_B: begin
        mx_a = {1'b0, bs_r};
        mx_b = {1'b0, bs_r};
      end
      DP_SQ_K: begin
        mx_a = {1'b0, ks_r};
        mx_b = {1'b0, ks_r};
      end
      DP_NMUL: begin
        mx_a = {1'b0, 31'(1 << 30) - ny};
        mx_b = {16'd0, span};
      end
      default: begin
        mx_a = '0;
        mx_b = '0;
      end
    endcase
  end

  assign prod = mx_a * mx_b;

  always_comb begin
    mx = K2;
    if (a_r > mx) mx = a_r;
    if (b_r > mx) mx = b_r;
    sh = '0;
    for (int i = 1; i <= 9; i++) begin
      if (mx[30+i]) sh = 4'(i);
    end
    a_sh = a_r >> sh;
    b_sh = b_r >> sh;
    k_sh = K2 >> sh;
  end

  assign trial = res_r + bit_r;
  assign t = {rem_r[32:0], dsh_r[30]};
  assign s = 47'((64'd1 << 45) + (64'd1 << 29)) - {1'b0, n_r};
  assign lit = s[46:30];

  always_comb begin
    if (lit < {1'b0, mv}) begin
      lit_c = mv;
    end else if (lit > {1'b0, ONE_Q15}) begin
      lit_c = ONE_Q15;
    end else begin
      lit_c = lit[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) h_r <= in_height;
    if (cmd.ld_l) hl_r <= ram_rdata;
    if (cmd.ld_r) hr_r <= ram_rdata;
    if (cmd.ld_d) hd_r <= ram_rdata;
    if (cmd.ld_u_mem) hu_r <= ram_rdata;
    if (cmd.ld_u_in) hu_r <= h_r;
    if (cmd.d_from_u) hd_r <= hu_r;
    case (cmd.op)
      DP_MUL_A: a_r <= prod[39:0];
      DP_MUL_B: b_r <= prod[39:0];
      DP_NORM: begin
        as_r <= a_sh[30:0];
        bs_r <= b_sh[30:0];
        ks_r <= k_sh[30:0];
      end
      DP_SQ_A: acc_r <= prod;
      DP_SQ_B, DP_SQ_K: acc_r <= acc_r + prod;
      DP_SQRT_INIT: begin
        v_r <= acc_r;
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      DP_SQRT_STEP: begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      DP_DIV_INIT: begin
        rem_r <= {4'd0, ks_r[30:1]};
        dsh_r <= {ks_r[0], 30'd0};
        q_r <= '0;
      end
      DP_DIV_STEP: begin
        if (t >= res_r[33:0]) begin
          rem_r <= t - res_r[33:0];
          q_r <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= t;
          q_r <= {q_r[29:0], 1'b0};
        end
        dsh_r <= {dsh_r[29:0], 1'b0};
      end
      DP_NMUL: n_r <= prod[45:0];
      default: begin
      end
    endcase
    if (cmd.op == DP_LIT && !stat.out_full) begin
      lit_r <= lit_c;
      last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_LIT && !stat.out_full) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_full = out_valid_r && !out_ready;
  assign height = h_r;
  assign out_valid = out_valid_r;
  assign out_lighting = lit_r;
  assign out_last = last_r;

endmodule
`default_nettype wire

### hw/rtl/heightmap_slope_lighting.sv
`default_nettype none
// Heightmap slope lighting.
// in_chan carries one item per pixel: opcode 0 is a height sample in raster
// order, opcode 1 a flush tick. Results on out_chan lag one row: each sample
// of row z+1 yields the lighting of the pixel above it, and once the frame
// has arrived, flush ticks yield the last row one pixel each, with
// frame_last on the final one. Samples beyond the frame and early flushes
// are dropped without a result.
// One item is worked at a time. A sample of the first row is only written
// to the row store; an item with a result runs through the 32-step square
// root and 31-step divide that share one datapath, and the block is ready
// for the next item once out valid rises.
// A finished result sits in an output register; a new item is accepted
// while it waits, and the block stalls before writing the next result
// until the receiver takes the old one.
// Configuration over the cfg APB port only while idle. Writing frame_size
// restarts the frame. Reset (rst_n low, synchronous) clears the counters
// and loads the register defaults; the row store needs no clearing.
module heightmap_slope_lighting
  import hsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  hsl_in_if.sink                  in_chan,
  hsl_out_if.source               out_chan,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready
);

  logic [SIZE_W-1:0] frame_size_r;
  logic [23:0]       slope_gain_r;
  logic [15:0]       min_bright_r;
  logic              wr_en, size_wr;
  logic [PADDR_W-3:0] idx;

  hsl_cmd_t          cmd;
  hsl_stat_t         stat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_rdata, wdata;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[PADDR_W-1:2];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign size_wr = wr_en && (idx == REG_FRAME_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
      slope_gain_r <= SLOPE_GAIN_RST;
      min_bright_r <= MIN_BRIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_SIZE: frame_size_r <= cfg_pwdata[SIZE_W-1:0];
        REG_SLOPE_GAIN: slope_gain_r <= cfg_pwdata[23:0];
        REG_MIN_BRIGHT: min_bright_r <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_SIZE: cfg_prdata = {21'd0, frame_size_r};
      REG_SLOPE_GAIN: cfg_prdata = {8'd0, slope_gain_r};
      REG_MIN_BRIGHT: cfg_prdata = {16'd0, min_bright_r};
      default: cfg_prdata = '0;
    endcase
  end

  hsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_opcode  (in_chan.opcode),
    .frame_size (frame_size_r),
    .size_wr    (size_wr),
    .stat       (stat),
    .cmd        (cmd),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_raddr  (ram_raddr)
  );

  hsl_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hsl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_height    (in_chan.height),
    .ram_rdata    (ram_rdata),
    .height       (wdata),
    .slope_gain   (slope_gain_r),
    .min_bright   (min_bright_r),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_lighting (out_chan.lighting),
    .out_last     (out_chan.frame_last)
  );

endmodule
`default_nettype wire
